// ----- rtl/fbwt_pkg.sv -----
// shared types and constants of the flash block write-back tracker
package fbwt_pkg;

  localparam int unsigned BLK_W       = 4;
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned NRES_W      = 5;

  typedef enum logic [2:0] {
    OP_CHANGED   = 3'd0,
    OP_SYNC_NOW  = 3'd1,
    OP_SYNC_LATE = 3'd2,
    OP_PROMOTE   = 3'd3,
    OP_SYNC_ALL  = 3'd4,
    OP_SCAN      = 3'd5,
    OP_INIT      = 3'd6
  } opcode_e;

  typedef enum logic [1:0] {
    BS_CONSISTENT = 2'd0,
    BS_DIRTY      = 2'd1,
    BS_CLEANING   = 2'd2,
    BS_CLEAN      = 2'd3
  } blk_state_e;

  typedef enum logic [1:0] {
    RQ_NONE = 2'd0,
    RQ_NOW  = 2'd1,
    RQ_LATE = 2'd2
  } sync_req_e;

  typedef enum logic [1:0] {
    CMD_ERASE  = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_FORMAT = 2'd2
  } cmd_e;

  // one table entry per block
  typedef struct packed {
    sync_req_e  rq;
    blk_state_e st;
  } entry_t;

  // classified event handed from the front to the back
  typedef struct packed {
    logic             marker;
    logic             ready;
    logic [BLK_W-1:0] blk;
    opcode_e          op;
  } job_t;

  // one bus command leaving the block
  typedef struct packed {
    logic             last;
    logic [BLK_W-1:0] blk;
    cmd_e             cmd;
  } result_t;

endpackage

// ----- rtl/fbwt_front.sv -----
// front stage: accepts events, drops those that do nothing, registers the rest
module fbwt_front #(
  parameter int unsigned BLOCKS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_vld_i,
  output logic          in_rdy_o,
  input  fbwt_pkg::job_t in_job_i,
  output logic          job_vld_o,
  input  logic          job_rdy_i,
  output fbwt_pkg::job_t job_o
);
  import fbwt_pkg::*;

  logic vld_q, vld_d;
  job_t job_q;
  logic keep;
  logic take;

  // block events out of range and the unused opcode cause nothing
  always_comb begin
    unique case (in_job_i.op) inside
      OP_CHANGED, OP_SYNC_NOW, OP_SYNC_LATE: keep = (32'(in_job_i.blk) < BLOCKS);
      OP_PROMOTE, OP_SYNC_ALL, OP_SCAN, OP_INIT: keep = 1'b1;
      default: keep = 1'b0;
    endcase
  end

  assign in_rdy_o = !vld_q || job_rdy_i;
  assign take     = in_vld_i && in_rdy_o;

  always_comb begin
    vld_d = vld_q;
    if (take) begin
      vld_d = keep;
    end else if (job_rdy_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      job_q <= in_job_i;
    end
  end

  assign job_vld_o = vld_q;
  assign job_o     = job_q;

endmodule

// ----- rtl/fbwt_queue.sv -----
// two-entry queue between the front and the back
module fbwt_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_vld_i,
  output logic           in_rdy_o,
  input  fbwt_pkg::job_t in_job_i,
  output logic           out_vld_o,
  input  logic           out_rdy_i,
  output fbwt_pkg::job_t out_job_o
);
  import fbwt_pkg::*;

  job_t       fifo_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign in_rdy_o  = (cnt_q != 2'd2);
  assign out_vld_o = (cnt_q != 2'd0);
  assign push      = in_vld_i && in_rdy_o;
  assign pop       = out_vld_o && out_rdy_i;
  assign out_job_o = fifo_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= in_job_i;
    end
  end

endmodule

// ----- rtl/fbwt_back.sv -----
// back engine: block table in memory, sweeps and single updates, command output
module fbwt_back #(
  parameter int unsigned BLOCKS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_vld_i,
  output logic              job_rdy_o,
  input  fbwt_pkg::job_t    job_i,
  output logic              res_vld_o,
  input  logic              res_rdy_i,
  output fbwt_pkg::result_t res_o
);
  import fbwt_pkg::*;

  localparam int unsigned AW = $clog2(BLOCKS);
  localparam logic [AW-1:0] LAST_IDX = AW'(BLOCKS - 1);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_RUN   = 3'b010,
    S_FLUSH = 3'b100
  } state_e;

  state_e           state_q, state_d;
  job_t             cur_q, cur_d;
  logic [AW-1:0]    idx_q, idx_d;
  logic [NRES_W-1:0] nres_q, nres_d;
  logic             erase_q, erase_d;
  entry_t           dflt_q, dflt_d;
  logic [BLOCKS-1:0] valid_q;
  logic             clr_valid;
  logic             hold_vld_q, hold_vld_d;
  result_t          hold_q, hold_d;
  logic             res_vld_q, res_vld_d;
  result_t          res_q;

  entry_t           mem_q [BLOCKS];
  entry_t           rd_q;
  logic [AW-1:0]    rd_addr;
  logic             mem_we;

  entry_t           ent, nent;
  logic             wr, emit, stop;
  cmd_e             emit_cmd;
  logic             single;
  logic             push, push_ok, stall;
  result_t          push_res;

  // an entry never written since the last init reads as the init value
  assign ent    = valid_q[idx_q] ? rd_q : dflt_q;
  assign single = (cur_q.op == OP_CHANGED) || (cur_q.op == OP_SYNC_NOW) ||
                  (cur_q.op == OP_SYNC_LATE);

  // per-block update rule
  always_comb begin
    nent     = ent;
    wr       = 1'b0;
    emit     = 1'b0;
    stop     = 1'b0;
    emit_cmd = CMD_WRITE;
    case (cur_q.op)
      OP_CHANGED: begin
        if (ent.st == BS_CONSISTENT) begin
          nent.st = BS_DIRTY;
          wr      = 1'b1;
        end
      end
      OP_SYNC_NOW, OP_SYNC_LATE: begin
        if (ent.st != BS_CONSISTENT) begin
          nent.rq = (cur_q.op == OP_SYNC_NOW) ? RQ_NOW : RQ_LATE;
          wr      = 1'b1;
        end
      end
      OP_PROMOTE: begin
        if (ent.rq == RQ_LATE) begin
          nent.rq = RQ_NOW;
          wr      = 1'b1;
        end
      end
      OP_SYNC_ALL: begin
        if (ent.st != BS_CONSISTENT) begin
          nent.rq = RQ_NOW;
          wr      = 1'b1;
        end
      end
      OP_SCAN: begin
        case (ent.st)
          BS_DIRTY: begin
            nent.st  = BS_CLEANING;
            wr       = 1'b1;
            emit     = 1'b1;
            emit_cmd = CMD_ERASE;
            stop     = 1'b1;
          end
          BS_CLEANING: begin
            nent.st = BS_CLEAN;
            wr      = 1'b1;
          end
          BS_CLEAN: begin
            if (ent.rq == RQ_NOW) begin
              nent.st  = BS_CONSISTENT;
              nent.rq  = RQ_NONE;
              wr       = 1'b1;
              emit     = 1'b1;
              emit_cmd = CMD_WRITE;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign push_ok = !res_vld_q || res_rdy_i;
  // a new command needs the held one to leave first
  assign stall   = emit && hold_vld_q && !push_ok;
  assign job_rdy_o = (state_q == S_IDLE);

  always_comb begin
    state_d    = state_q;
    cur_d      = cur_q;
    idx_d      = idx_q;
    nres_d     = nres_q;
    erase_d    = erase_q;
    dflt_d     = dflt_q;
    clr_valid  = 1'b0;
    hold_vld_d = hold_vld_q;
    hold_d     = hold_q;
    push       = 1'b0;
    push_res   = hold_q;
    mem_we     = 1'b0;
    rd_addr    = idx_q;
    unique case (state_q)
      S_IDLE: begin
        if (job_vld_i) begin
          cur_d  = job_i;
          nres_d = '0;
          unique case (job_i.op) inside
            OP_CHANGED, OP_SYNC_NOW, OP_SYNC_LATE: begin
              idx_d   = AW'(job_i.blk);
              rd_addr = AW'(job_i.blk);
              state_d = S_RUN;
            end
            OP_PROMOTE, OP_SYNC_ALL: begin
              idx_d   = '0;
              rd_addr = '0;
              state_d = S_RUN;
            end
            OP_SCAN: begin
              if (!(erase_q && !job_i.ready)) begin
                erase_d = 1'b0;
                idx_d   = '0;
                rd_addr = '0;
                state_d = S_RUN;
              end
            end
            OP_INIT: begin
              erase_d   = 1'b0;
              clr_valid = 1'b1;
              if (job_i.marker) begin
                dflt_d = '{rq: RQ_NONE, st: BS_CONSISTENT};
              end else begin
                dflt_d     = '{rq: RQ_NOW, st: BS_CLEAN};
                hold_vld_d = 1'b1;
                hold_d     = '{last: 1'b0, blk: '0, cmd: CMD_FORMAT};
                state_d    = S_FLUSH;
              end
            end
            default: ;
          endcase
        end
      end
      S_RUN: begin
        if (!stall) begin
          mem_we = wr;
          if (emit) begin
            if (hold_vld_q) begin
              push          = 1'b1;
              push_res.last = 1'b0;
            end
            hold_vld_d = 1'b1;
            hold_d     = '{last: 1'b0, blk: BLK_W'(idx_q), cmd: emit_cmd};
            nres_d     = nres_q + NRES_W'(1);
            if (emit_cmd == CMD_ERASE) begin
              erase_d = 1'b1;
            end
          end
          if (single || stop || (idx_q == LAST_IDX) ||
              (emit && (nres_d == NRES_W'(MAX_RESULTS)))) begin
            state_d = hold_vld_d ? S_FLUSH : S_IDLE;
          end else begin
            idx_d   = idx_q + AW'(1);
            rd_addr = idx_q + AW'(1);
          end
        end
      end
      S_FLUSH: begin
        if (push_ok) begin
          push          = 1'b1;
          push_res.last = 1'b1;
          hold_vld_d    = 1'b0;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    res_vld_d = res_vld_q;
    if (push) begin
      res_vld_d = 1'b1;
    end else if (res_rdy_i) begin
      res_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      nres_q     <= '0;
      erase_q    <= 1'b0;
      dflt_q     <= '{rq: RQ_NONE, st: BS_CONSISTENT};
      hold_vld_q <= 1'b0;
      res_vld_q  <= 1'b0;
      valid_q    <= '0;
    end else begin
      state_q    <= state_d;
      nres_q     <= nres_d;
      erase_q    <= erase_d;
      dflt_q     <= dflt_d;
      hold_vld_q <= hold_vld_d;
      res_vld_q  <= res_vld_d;
      if (clr_valid) begin
        valid_q <= '0;
      end else if (mem_we) begin
        valid_q[idx_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    idx_q  <= idx_d;
    hold_q <= hold_d;
    if (push) begin
      res_q <= push_res;
    end
  end

  // block table
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[idx_q] <= nent;
    end
    rd_q <= mem_q[rd_addr];
  end

  assign res_vld_o = res_vld_q;
  assign res_o     = res_q;

  a_hold_not_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_vld_q |-> (state_q != S_IDLE))
    else $error("held command while idle");

  a_nonlast_keeps_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !push_res.last) |=> hold_vld_q)
    else $error("non-final command without a successor");

  a_erase_from_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(erase_q) |-> (hold_vld_q && (hold_q.cmd == CMD_ERASE)))
    else $error("erase pending without erase command");

  a_nres_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nres_q <= NRES_W'(MAX_RESULTS))
    else $error("too many commands in one scan");

endmodule

// ----- rtl/flash_block_writeback_tracker_core.sv -----
// top level of the flash block write-back tracker
//
// usage: each item on the s_axis side is one event for the block table
// (changed, sync now, sync late, promote late, sync all, scan, init); the
// m_axis side carries the bus commands (erase, write, format) that events
// cause, with tlast on the final command of an event.
// a front stage drops events that do nothing and registers the rest, a
// two-entry queue holds them, and the back engine works on one at a time.
// the back finishes an init with the marker, and a scan dropped while an
// erase is pending, in its idle state; an init without the marker goes to
// the flush state, a single-block event takes one run step, and a sweep
// (promote, sync all, scan) walks the block table memory, one block per
// cycle through its registered read port while no command stalls, then
// flushes if a scan sent a command. events pass the front register and
// the queue before the back. a command is held until the walk finds the
// next one or ends, so tlast is known; the final one leaves via the flush.
// reset empties the queue and output and makes every block consistent with
// no request, without a clearing pass.
// a stalled receiver holds the output register; the back then waits on the
// next command to send while the front and queue take items until full
module flash_block_writeback_tracker_core #(
  parameter int unsigned BLOCKS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,  // [3:0] block_index, [4] flash_ready, [5] marker_found
  input  logic [2:0] s_axis_tuser,  // [2:0] opcode
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,  // [3:0] target_block
  output logic [1:0] m_axis_tuser,  // [1:0] command
  output logic       m_axis_tlast
);
  import fbwt_pkg::*;

  job_t    in_job;
  logic    fq_vld, fq_rdy;
  job_t    fq_job;
  logic    qb_vld, qb_rdy;
  job_t    qb_job;
  result_t res;

  // unpack the event
  assign in_job.op     = opcode_e'(s_axis_tuser);
  assign in_job.blk    = s_axis_tdata[3:0];
  assign in_job.ready  = s_axis_tdata[4];
  assign in_job.marker = s_axis_tdata[5];

  fbwt_front #(
    .BLOCKS(BLOCKS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_vld_i (s_axis_tvalid),
    .in_rdy_o (s_axis_tready),
    .in_job_i (in_job),
    .job_vld_o(fq_vld),
    .job_rdy_i(fq_rdy),
    .job_o    (fq_job)
  );

  // decouples classification from the table walk
  fbwt_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_vld_i (fq_vld),
    .in_rdy_o (fq_rdy),
    .in_job_i (fq_job),
    .out_vld_o(qb_vld),
    .out_rdy_i(qb_rdy),
    .out_job_o(qb_job)
  );

  fbwt_back #(
    .BLOCKS(BLOCKS)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .job_vld_i(qb_vld),
    .job_rdy_o(qb_rdy),
    .job_i    (qb_job),
    .res_vld_o(m_axis_tvalid),
    .res_rdy_i(m_axis_tready),
    .res_o    (res)
  );

  // pack the command item
  assign m_axis_tdata = {4'b0000, res.blk};
  assign m_axis_tuser = res.cmd;
  assign m_axis_tlast = res.last;

endmodule

// ----- tb/flash_block_writeback_tracker_core_tb.sv -----
// self-checking testbench of the flash block write-back tracker core
module flash_block_writeback_tracker_core_tb;
  import fbwt_pkg::*;

  localparam int unsigned BLOCKS = 16;
  // tuser code that no event uses, the block must drop it
  localparam logic [2:0] OP_UNUSED = 3'd7;
  // cycles without any handshake before the run is declared hung
  localparam int unsigned STALL_LIMIT = 4000;
  // long receiver hold-off, long enough to back the block up to its input
  localparam int unsigned HOLD_CYCLES = 300;
  // settle time after the last expected command, a sweep plus output delay
  localparam int unsigned DRAIN_CYCLES = 2 * BLOCKS + 8;
  localparam int unsigned RUN_ITEMS = 64;

  // keeps its own copy of the block table and queues the bus commands that
  // every accepted event must produce, in order
  class writeback_scoreboard;
    blk_state_e blk_st[BLOCKS];
    sync_req_e  blk_rq[BLOCKS];
    bit         erase_wait;
    result_t    pending_cmds[$];
    int         fail_cnt;

    function new();
      foreach (blk_st[i]) begin
        blk_st[i] = BS_CONSISTENT;
        blk_rq[i] = RQ_NONE;
      end
      erase_wait = 1'b0;
      fail_cnt = 0;
    endfunction

    function void note_event(logic [2:0] op, logic [3:0] blk, logic ready, logic marker);
      int n;
      bit stop;
      result_t r;
      result_t tail;
      n = 0;
      stop = 1'b0;
      case (op)
        OP_CHANGED: begin
          if (blk < BLOCKS && blk_st[blk] == BS_CONSISTENT) blk_st[blk] = BS_DIRTY;
        end
        OP_SYNC_NOW, OP_SYNC_LATE: begin
          if (blk < BLOCKS && blk_st[blk] != BS_CONSISTENT)
            blk_rq[blk] = (op == OP_SYNC_NOW) ? RQ_NOW : RQ_LATE;
        end
        OP_PROMOTE: begin
          foreach (blk_rq[i]) if (blk_rq[i] == RQ_LATE) blk_rq[i] = RQ_NOW;
        end
        OP_SYNC_ALL: begin
          foreach (blk_st[i]) if (blk_st[i] != BS_CONSISTENT) blk_rq[i] = RQ_NOW;
        end
        OP_SCAN: begin
          // a scan is dropped while an erase is still running in flash
          if (!(erase_wait && !ready)) begin
            erase_wait = 1'b0;
            for (int i = 0; i < BLOCKS && n < MAX_RESULTS && !stop; i++) begin
              case (blk_st[i])
                BS_DIRTY: begin
                  // first dirty block is erased and ends the walk
                  blk_st[i] = BS_CLEANING;
                  r.cmd = CMD_ERASE;
                  r.blk = i[3:0];
                  r.last = 1'b0;
                  pending_cmds.push_back(r);
                  n++;
                  erase_wait = 1'b1;
                  stop = 1'b1;
                end
                BS_CLEANING: blk_st[i] = BS_CLEAN;
                BS_CLEAN: begin
                  // only a now request writes, a late one waits
                  if (blk_rq[i] == RQ_NOW) begin
                    r.cmd = CMD_WRITE;
                    r.blk = i[3:0];
                    r.last = 1'b0;
                    pending_cmds.push_back(r);
                    n++;
                    blk_st[i] = BS_CONSISTENT;
                    blk_rq[i] = RQ_NONE;
                  end
                end
                default: ;
              endcase
            end
          end
        end
        OP_INIT: begin
          erase_wait = 1'b0;
          foreach (blk_st[i]) begin
            blk_st[i] = marker ? BS_CONSISTENT : BS_CLEAN;
            blk_rq[i] = marker ? RQ_NONE : RQ_NOW;
          end
          if (!marker) begin
            r.cmd = CMD_FORMAT;
            r.blk = '0;
            r.last = 1'b0;
            pending_cmds.push_back(r);
            n++;
          end
        end
        default: ;
      endcase
      if (n > 0) begin
        tail = pending_cmds.pop_back();
        tail.last = 1'b1;
        pending_cmds.push_back(tail);
      end
    endfunction

    function void check_command(logic [1:0] cmd, logic [7:0] data, logic last);
      result_t want;
      if (pending_cmds.size() == 0) begin
        if (fail_cnt < 10)
          $display("unexpected command: cmd %0d data 0x%02h last %0d", cmd, data, last);
        fail_cnt++;
        return;
      end
      want = pending_cmds.pop_front();
      if (cmd !== want.cmd || data !== {4'b0000, want.blk} || last !== want.last) begin
        if (fail_cnt < 10)
          $display({"command mismatch: expected cmd %0d block %0d last %0d, ",
                    "got cmd %0d data 0x%02h last %0d"},
                   want.cmd, want.blk, want.last, cmd, data, last);
        fail_cnt++;
      end
    endfunction

    function int outstanding();
      return pending_cmds.size();
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;   // [3:0] block_index, [4] flash_ready, [5] marker_found
  logic [2:0] s_axis_tuser;   // [2:0] opcode
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;   // [3:0] target_block
  logic [1:0] m_axis_tuser;   // [1:0] command
  logic       m_axis_tlast;

  writeback_scoreboard sb;

  // idle rates of both sides in percent, set per phase by the stimulus
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  // the stimulus bumps hold_req, the receiver process then runs one hold-off
  int unsigned hold_req;
  int unsigned hold_done = 0;
  int unsigned quiet_cycles = 0;

  flash_block_writeback_tracker_core #(
    .BLOCKS(BLOCKS)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // output monitor and hang watchdog, both on the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready)
        sb.check_command(m_axis_tuser, m_axis_tdata, m_axis_tlast);
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("tb: failure");
          $finish;
        end
      end
    end
  end

  // receiver: random backpressure, or one long hold-off when asked for,
  // counted here so the sender keeps offering items meanwhile
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_done != hold_req) begin
        hold_done = hold_req;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // offer one event, optionally after random idle cycles, and hand it to the
  // scoreboard at the edge where it is taken; returns just after a falling edge
  task automatic send_event(logic [2:0] op, logic [3:0] blk, logic ready, logic marker);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {2'b00, marker, ready, blk};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_event(op, blk, ready, marker);
    @(negedge clk_i);
  endtask

  // sender goes quiet until every expected command has left the block
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (sb.outstanding() != 0);
  endtask

  // random events weighted toward change / scan sequences so blocks keep
  // cycling through dirty, cleaning, clean and back to consistent
  task automatic send_random_run(int unsigned count);
    int unsigned sent;
    int unsigned pick;
    logic [2:0]  op;
    logic        ready;
    logic        marker;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 25) op = OP_CHANGED;
      else if (pick < 37) op = OP_SYNC_NOW;
      else if (pick < 45) op = OP_SYNC_LATE;
      else if (pick < 50) op = OP_PROMOTE;
      else if (pick < 55) op = OP_SYNC_ALL;
      else if (pick < 89) op = OP_SCAN;
      else if (pick < 96) op = OP_INIT;
      else op = OP_UNUSED;
      // flash mostly ready, marker mostly present so init rarely formats
      ready = ($urandom_range(3) != 0);
      marker = ($urandom_range(3) != 0);
      send_event(op, 4'($urandom_range(15)), ready, marker);
      if (op != OP_UNUSED) sent++;
    end
  endtask

  initial begin
    sb = new();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req = 0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed part: extremes of the fields and every event kind
    send_event(OP_INIT, 4'd0, 1'b0, 1'b1);
    send_event(OP_UNUSED, 4'd15, 1'b1, 1'b1);       // ignored code, all bits high
    send_event(OP_CHANGED, 4'd0, 1'b0, 1'b0);
    send_event(OP_CHANGED, 4'd15, 1'b1, 1'b0);
    send_event(OP_CHANGED, 4'd15, 1'b0, 1'b0);      // already dirty, stays dirty
    send_event(OP_SYNC_LATE, 4'd15, 1'b0, 1'b0);
    send_event(OP_SYNC_NOW, 4'd3, 1'b0, 1'b0);      // consistent block, no effect
    send_event(OP_SCAN, 4'd0, 1'b0, 1'b0);          // erase block 0
    send_event(OP_SCAN, 4'd0, 1'b0, 1'b0);          // erase busy, scan dropped
    send_event(OP_SCAN, 4'd0, 1'b1, 1'b0);          // block 0 clean, erase 15
    send_event(OP_SYNC_NOW, 4'd0, 1'b0, 1'b0);
    send_event(OP_SCAN, 4'd0, 1'b1, 1'b0);          // write 0, block 15 clean
    send_event(OP_SCAN, 4'd0, 1'b1, 1'b0);          // late request is not written
    send_event(OP_PROMOTE, 4'd0, 1'b0, 1'b0);
    send_event(OP_SCAN, 4'd0, 1'b1, 1'b0);          // now write 15
    send_event(OP_CHANGED, 4'd5, 1'b0, 1'b0);
    send_event(OP_CHANGED, 4'd6, 1'b0, 1'b0);
    send_event(OP_SYNC_ALL, 4'd0, 1'b0, 1'b0);
    send_event(OP_SCAN, 4'd0, 1'b1, 1'b0);
    send_event(OP_SCAN, 4'd0, 1'b1, 1'b0);
    send_event(OP_SCAN, 4'd0, 1'b1, 1'b0);
    send_event(OP_INIT, 4'd0, 1'b1, 1'b0);          // no marker, format
    send_event(OP_SCAN, 4'd0, 1'b1, 1'b0);          // writes every block
    wait_drained();

    // sender idles more rarely than the receiver
    tx_idle_pct = 30;
    rx_idle_pct = 68;
    send_random_run(RUN_ITEMS);
    wait_drained();

    // the other way round
    tx_idle_pct = 68;
    rx_idle_pct = 30;
    send_random_run(RUN_ITEMS);
    wait_drained();

    // no idling; start with a long receiver hold-off while a format and a
    // full write sweep are pushed in, so the block fills and stalls its input
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req++;
    send_event(OP_INIT, 4'd0, 1'b1, 1'b0);
    send_event(OP_SCAN, 4'd0, 1'b1, 1'b0);
    send_event(OP_CHANGED, 4'd1, 1'b0, 1'b0);
    send_event(OP_CHANGED, 4'd2, 1'b0, 1'b0);
    send_event(OP_SCAN, 4'd0, 1'b1, 1'b0);
    send_event(OP_SCAN, 4'd0, 1'b1, 1'b0);
    send_event(OP_SYNC_ALL, 4'd0, 1'b0, 1'b0);
    send_event(OP_SCAN, 4'd0, 1'b1, 1'b0);
    send_random_run(RUN_ITEMS);
    wait_drained();

    // let any event still in the engine come out before judging
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (sb.fail_cnt == 0 && sb.outstanding() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
